@@ rtl/mesp_pkg.sv @@
// Shared types and constants of the encoder speed poller.
`default_nettype none
package mesp_pkg;

   localparam int DEFAULT_ENCODER_SPAN = 4096;

   localparam logic [7:0]  STATION_RESET = 8'd2;
   localparam logic [15:0] START_RESET   = 16'd0;
   localparam logic [6:0]  COUNT_RESET   = 7'd1;

   localparam logic [1:0] CSR_STATION = 2'd0;
   localparam logic [1:0] CSR_START   = 2'd1;
   localparam logic [1:0] CSR_COUNT   = 2'd2;

   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [9:0] SPEED_SCALE       = 10'd1000;

   localparam int QUO_W     = 26;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [2:0] TX_LAST = 3'd7;

   localparam logic       KIND_TX   = 1'b0;
   localparam logic       KIND_MEAS = 1'b1;

   typedef struct packed {
      logic       take;
      logic       load_tx;
      logic [2:0] tx_idx;
      logic       mul_go;
      logic       div_step;
      logic       load_meas;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic ivl_zero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/mesp_ctrl.sv @@
// Controller state machine of the encoder speed poller.
`default_nettype none
module mesp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_action,
   output logic                 req_stall,
   input  mesp_pkg::status_type status,
   output mesp_pkg::cmd_type    cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEND = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      cmd.tx_idx = cnt_ff[2:0];
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               cnt_in   = '0;
               if (req_action) begin
                  state_in = S_SEND;
               end else if (status.hit) begin
                  state_in = status.ivl_zero ? S_EMIT : S_MUL;
               end
            end
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.load_tx = 1'b1;
               if (cnt_ff[2:0] == mesp_pkg::TX_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            cnt_in     = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'(mesp_pkg::DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_meas = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/mesp_dp.sv @@
// Datapath of the encoder speed poller: registers, CRC, wrap, divider, output beat.
`default_nettype none
module mesp_dp #(
   parameter int ENCODER_SPAN = mesp_pkg::DEFAULT_ENCODER_SPAN
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_wr_en,
   input  wire  [1:0]            csr_index,
   input  wire  [15:0]           csr_wdata,
   input  wire                   req_action,
   input  wire  [7:0]            req_rx_byte,
   input  wire  [31:0]           req_now_tick,
   input  wire                   rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_last_byte,
   output logic [15:0]           rsp_position,
   output logic [15:0]           rsp_interval,
   output logic signed [15:0]    rsp_delta,
   output logic signed [15:0]    rsp_speed,
   output logic [15:0]           rsp_good_count,
   output logic [15:0]           rsp_error_count,
   input  mesp_pkg::cmd_type     cmd,
   output mesp_pkg::status_type  status
);
   localparam logic [16:0] SPAN_W = 17'(ENCODER_SPAN);
   localparam logic [16:0] LO_W   = 17'(ENCODER_SPAN / 4);
   localparam logic [16:0] HI_W   = 17'(ENCODER_SPAN - ENCODER_SPAN / 4);

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   logic [7:0]  station_ff;
   logic [15:0] start_ff;
   logic [6:0]  count_ff;
   logic [7:0]  rx_count_ff;
   logic [7:0]  hdr_ff [5];
   logic        pending_ff;
   logic [15:0] prev_pos_ff;
   logic [31:0] prev_tick_ff;
   logic [15:0] last_speed_ff;
   logic [15:0] good_ff;
   logic [15:0] err_ff;
   logic [15:0] crc_ff;
   logic [15:0] pos_ff;
   logic [15:0] ivl_ff;
   logic [15:0] delta_ff;
   logic        neg_ff;
   logic [mesp_pkg::QUO_W-1:0] quo_ff;
   logic [15:0] rem_ff;
   logic        valid_ff;

   // Header as it stands once the incoming byte is written.
   logic [7:0]  hv [5];
   logic [7:0]  rx_new;
   logic [8:0]  need;
   logic [15:0] pos_new;
   logic [31:0] tick_diff;
   logic [15:0] ivl_new;
   logic [15:0] delta_new;
   logic        rx_take;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         hv[k] = (rx_count_ff == 8'(k)) ? req_rx_byte : hdr_ff[k];
      end
      rx_new    = (rx_count_ff == 8'hFF) ? rx_count_ff : rx_count_ff + 8'd1;
      need      = {1'b0, count_ff, 1'b0} + 9'd5;
      pos_new   = {hv[3], hv[4]};
      tick_diff = req_now_tick - prev_tick_ff;
      ivl_new   = tick_diff[15:0];
      delta_new = pos_new - prev_pos_ff;
      if ({1'b0, pos_new} < LO_W && {1'b0, prev_pos_ff} > HI_W) begin
         delta_new = delta_new + SPAN_W[15:0];
      end else if ({1'b0, pos_new} > HI_W && {1'b0, prev_pos_ff} < LO_W) begin
         delta_new = delta_new - SPAN_W[15:0];
      end
      rx_take         = cmd.take && !req_action;
      status.hit      = ({1'b0, rx_new} >= need) && (hv[0] == station_ff)
                        && (hv[1] == mesp_pkg::FUNC_READ_HOLDING)
                        && (hv[2] == {count_ff, 1'b0});
      status.ivl_zero = (ivl_new == 16'd0);
      status.out_free = !valid_ff || !rsp_stall;
   end

   // Frame byte and CRC for the current transmit beat.
   logic [7:0] frame_byte;
   always_comb begin
      unique case (cmd.tx_idx)
         3'd0:    frame_byte = station_ff;
         3'd1:    frame_byte = mesp_pkg::FUNC_READ_HOLDING;
         3'd2:    frame_byte = start_ff[15:8];
         3'd3:    frame_byte = start_ff[7:0];
         3'd4:    frame_byte = 8'h00;
         3'd5:    frame_byte = {1'b0, count_ff};
         3'd6:    frame_byte = crc_ff[7:0];
         default: frame_byte = crc_ff[15:8];
      endcase
   end

   // Divider step and speed saturation.
   logic [16:0] shifted;
   logic [16:0] trial;
   logic [15:0] mag;
   logic [15:0] speed_sat;
   logic [15:0] speed_out;
   always_comb begin
      shifted = {rem_ff, quo_ff[mesp_pkg::QUO_W-1]};
      trial   = shifted - {1'b0, ivl_ff};
      mag     = delta_ff[15] ? (16'd0 - delta_ff) : delta_ff;
      if (neg_ff) begin
         speed_sat = (quo_ff > mesp_pkg::QUO_W'(32768)) ? 16'h8000 : (16'd0 - quo_ff[15:0]);
      end else begin
         speed_sat = (quo_ff > mesp_pkg::QUO_W'(32767)) ? 16'h7FFF : quo_ff[15:0];
      end
      speed_out = (ivl_ff == 16'd0) ? last_speed_ff : speed_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff    <= mesp_pkg::STATION_RESET;
         start_ff      <= mesp_pkg::START_RESET;
         count_ff      <= mesp_pkg::COUNT_RESET;
         rx_count_ff   <= '0;
         pending_ff    <= 1'b0;
         prev_pos_ff   <= '0;
         prev_tick_ff  <= '0;
         last_speed_ff <= '0;
         good_ff       <= '0;
         err_ff        <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               mesp_pkg::CSR_STATION: station_ff <= csr_wdata[7:0];
               mesp_pkg::CSR_START:   start_ff   <= csr_wdata;
               mesp_pkg::CSR_COUNT:   count_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (cmd.take && req_action) begin
            if (pending_ff) begin
               err_ff <= err_ff + 16'd1;
            end
            rx_count_ff <= '0;
            pending_ff  <= 1'b1;
         end
         if (rx_take) begin
            if (status.hit) begin
               rx_count_ff  <= '0;
               pending_ff   <= 1'b0;
               prev_pos_ff  <= pos_new;
               prev_tick_ff <= req_now_tick;
               good_ff      <= good_ff + 16'd1;
            end else begin
               rx_count_ff <= rx_new;
            end
         end
         if (cmd.load_meas) begin
            last_speed_ff <= speed_out;
         end
         if (cmd.load_tx || cmd.load_meas) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (rx_take) begin
         for (int k = 0; k < 5; k++) begin
            if (rx_count_ff == 8'(k)) begin
               hdr_ff[k] <= req_rx_byte;
            end
         end
         pos_ff   <= pos_new;
         ivl_ff   <= ivl_new;
         delta_ff <= delta_new;
      end
      if (cmd.take && req_action) begin
         crc_ff <= 16'hFFFF;
      end else if (cmd.load_tx && cmd.tx_idx < 3'd6) begin
         crc_ff <= crc_byte(crc_ff, frame_byte);
      end
      if (cmd.mul_go) begin
         neg_ff <= delta_ff[15];
         quo_ff <= mesp_pkg::QUO_W'(mag) * mesp_pkg::QUO_W'(mesp_pkg::SPEED_SCALE);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[16]) begin
            rem_ff <= trial[15:0];
            quo_ff <= {quo_ff[mesp_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[15:0];
            quo_ff <= {quo_ff[mesp_pkg::QUO_W-2:0], 1'b0};
         end
      end
      if (cmd.load_tx) begin
         rsp_kind        <= mesp_pkg::KIND_TX;
         rsp_tx_byte     <= frame_byte;
         rsp_last_byte   <= (cmd.tx_idx == mesp_pkg::TX_LAST);
         rsp_position    <= '0;
         rsp_interval    <= '0;
         rsp_delta       <= '0;
         rsp_speed       <= '0;
         rsp_good_count  <= good_ff;
         rsp_error_count <= err_ff;
      end else if (cmd.load_meas) begin
         rsp_kind        <= mesp_pkg::KIND_MEAS;
         rsp_tx_byte     <= '0;
         rsp_last_byte   <= 1'b0;
         rsp_position    <= pos_ff;
         rsp_interval    <= ivl_ff;
         rsp_delta       <= delta_ff;
         rsp_speed       <= speed_out;
         rsp_good_count  <= good_ff;
         rsp_error_count <= err_ff;
      end
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

@@ rtl/modbus_encoder_speed_poller_top.sv @@
// Top level of the Modbus RTU encoder speed poller.
`default_nettype none
// Modbus RTU master that polls an absolute encoder with read-holding-registers
// requests and reports position, interval, wrap-corrected delta and speed.
// A send beat (action 1) produces eight transmit beats, the request frame with
// its CRC-16 low byte first; each is loaded when the output is not stalled.
// A received byte that does not complete a matching reply is taken without a
// stall; the byte that completes a matching reply is captured, then delta is
// scaled by 1000, the restoring divider runs (one quotient bit per cycle) and
// the measurement is emitted. When the interval is zero the divider is skipped
// and the previous speed is repeated. The input stalls while a send or a
// measurement is in progress. The reply CRC is not checked. Registers:
// 0 station, 1 start register, 2 register count.
module modbus_encoder_speed_poller_top #(
   parameter int ENCODER_SPAN = mesp_pkg::DEFAULT_ENCODER_SPAN
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [15:0]        csr_wdata,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_action,
   input  wire  [7:0]         req_rx_byte,
   input  wire  [31:0]        req_now_tick,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_kind,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last_byte,
   output logic [15:0]        rsp_position,
   output logic [15:0]        rsp_interval,
   output logic signed [15:0] rsp_delta,
   output logic signed [15:0] rsp_speed,
   output logic [15:0]        rsp_good_count,
   output logic [15:0]        rsp_error_count
);
   mesp_pkg::cmd_type    cmd;
   mesp_pkg::status_type status;

   // Sequence sends and measurements; only it decides when a beat is taken.
   mesp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold configuration and measurement state, build frames, match replies and run the divider.
   mesp_dp #(
      .ENCODER_SPAN (ENCODER_SPAN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .req_now_tick    (req_now_tick),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_position    (rsp_position),
      .rsp_interval    (rsp_interval),
      .rsp_delta       (rsp_delta),
      .rsp_speed       (rsp_speed),
      .rsp_good_count  (rsp_good_count),
      .rsp_error_count (rsp_error_count),
      .cmd             (cmd),
      .status          (status)
   );

   // A send beat keeps the input stalled while the frame goes out.
   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action) |=> req_stall)
      else $error("input not stalled after send beat");

   // The closing frame byte is always a transmit beat.
   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_kind == mesp_pkg::KIND_TX))
      else $error("last byte flag on a measurement beat");

   // A measurement beat carries no frame byte.
   a_meas_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mesp_pkg::KIND_MEAS) |-> (rsp_tx_byte == 8'h00))
      else $error("measurement beat carries a frame byte");
endmodule
`default_nettype wire

@@ test/tb_modbus_encoder_speed_poller_top.sv @@
// Self-checking testbench of the Modbus RTU encoder speed poller.
`timescale 1ns / 1ps
module tb_modbus_encoder_speed_poller_top;

   // Result beat as the block presents it.
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [15:0] position;
      logic [15:0] interval;
      logic [15:0] delta;
      logic [15:0] speed;
      logic [15:0] good_count;
      logic [15:0] error_count;
   } poll_beat_type;

   localparam int SPAN       = mesp_pkg::DEFAULT_ENCODER_SPAN;
   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [7:0]  req_rx_byte = '0;
   logic [31:0] req_now_tick = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;
   logic [15:0] rsp_position;
   logic [15:0] rsp_interval;
   logic signed [15:0] rsp_delta;
   logic signed [15:0] rsp_speed;
   logic [15:0] rsp_good_count;
   logic [15:0] rsp_error_count;

   modbus_encoder_speed_poller_top DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor copy of the block's configuration and state.
   logic [7:0]  cfg_station;
   logic [15:0] cfg_start;
   logic [6:0]  cfg_count;
   logic [7:0]  rx_seen;
   logic [7:0]  hdr [5];
   logic        awaiting_reply;
   logic [15:0] last_pos;
   logic [31:0] last_tick;
   logic [15:0] held_speed;
   logic [15:0] good_total;
   logic [15:0] error_total;

   poll_beat_type expected_beats[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;     // long receiver stall, set by the pressure test
   bit  rsp_quiet = 1'b0;    // turn off random receiver stalls

   function automatic logic [15:0] modbus_crc16(input logic [7:0] frame [8]);
      logic [15:0] crc;
      crc = 16'hFFFF;
      for (int i = 0; i < 6; i++) begin
         crc ^= {8'h00, frame[i]};
         for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
         end
      end
      return crc;
   endfunction

   // Work out the beats that one accepted item causes and queue them.
   task automatic predict_poll(input logic act, input logic [7:0] rxb, input logic [31:0] now);
      logic [7:0]  frame [8];
      logic [15:0] crc, pos, ivl, du;
      int          np, op, d, s, need;
      poll_beat_type e;
      if (act) begin
         if (awaiting_reply) error_total++;
         rx_seen = 0;
         awaiting_reply = 1'b1;
         frame[0] = cfg_station;
         frame[1] = mesp_pkg::FUNC_READ_HOLDING;
         frame[2] = cfg_start[15:8];
         frame[3] = cfg_start[7:0];
         frame[4] = 8'h00;
         frame[5] = {1'b0, cfg_count};
         crc = modbus_crc16(frame);
         frame[6] = crc[7:0];
         frame[7] = crc[15:8];
         for (int i = 0; i < 8; i++) begin
            e = '0;
            e.kind = mesp_pkg::KIND_TX;
            e.tx_byte = frame[i];
            e.last_byte = (i == 7);
            e.good_count = good_total;
            e.error_count = error_total;
            expected_beats.push_back(e);
         end
         return;
      end
      if (rx_seen < 5) hdr[rx_seen] = rxb;
      if (rx_seen < 255) rx_seen++;
      need = 2 * cfg_count + 5;
      if (rx_seen < need) return;
      if (hdr[0] != cfg_station || hdr[1] != mesp_pkg::FUNC_READ_HOLDING) return;
      if (hdr[2] != 8'(2 * cfg_count)) return;
      pos = {hdr[3], hdr[4]};
      ivl = 16'(now - last_tick);
      last_tick = now;
      np = pos;
      op = last_pos;
      d = np - op;
      if (np < SPAN / 4 && op > SPAN - SPAN / 4) d += SPAN;
      if (np > SPAN - SPAN / 4 && op < SPAN / 4) d -= SPAN;
      du = 16'(d);
      if (ivl != 0) begin
         // Truncating signed divide, then clamp to 16 bits.
         s = (int'($signed(du)) * 1000) / int'(ivl);
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         held_speed = 16'(s);
      end
      last_pos = pos;
      good_total++;
      awaiting_reply = 1'b0;
      rx_seen = 0;
      e = '0;
      e.kind = mesp_pkg::KIND_MEAS;
      e.position = pos;
      e.interval = ivl;
      e.delta = du;
      e.speed = held_speed;
      e.good_count = good_total;
      e.error_count = error_total;
      expected_beats.push_back(e);
   endtask

   // Random gap: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one beat and hold it until accepted.
   task automatic send_item(input logic act, input logic [7:0] rxb, input logic [31:0] now);
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= rxb;
      req_now_tick <= now;
      do @(posedge clock); while (req_stall);
      predict_poll(act, rxb, now);
   endtask

   task automatic send_gapped(input logic act, input logic [7:0] rxb, input logic [31:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_item(act, rxb, now);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every queued beat has come back, then let a full measurement drain.
   task automatic drain();
      go_quiet();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         mesp_pkg::CSR_STATION: cfg_station = val[7:0];
         mesp_pkg::CSR_START:   cfg_start = val;
         mesp_pkg::CSR_COUNT:   cfg_count = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_poll_config(input logic [7:0] st, input logic [15:0] sr, input logic [6:0] cnt);
      write_csr(mesp_pkg::CSR_STATION, {8'h00, st});
      write_csr(mesp_pkg::CSR_START, sr);
      write_csr(mesp_pkg::CSR_COUNT, {9'h000, cnt});
      csr_wr_en <= 1'b0;
   endtask

   // Full reply: a good header, payload with position in the first register.
   task automatic send_reply(input logic [15:0] pos, input logic [31:0] now,
                             input bit gapped, input int corrupt_at);
      logic [7:0] b;
      int         len;
      len = 2 * cfg_count + 5;
      for (int i = 0; i < len; i++) begin
         case (i)
            0: b = cfg_station;
            1: b = mesp_pkg::FUNC_READ_HOLDING;
            2: b = 8'(2 * cfg_count);
            3: b = pos[15:8];
            4: b = pos[7:0];
            default: b = 8'($urandom);
         endcase
         if (i == corrupt_at) b = b ^ 8'(1 << $urandom_range(0, 7));
         if (gapped) send_gapped(1'b0, b, now);
         else send_item(1'b0, b, now);
      end
   endtask

   task automatic poll_once(input logic [15:0] pos, input logic [31:0] now, input bit gapped);
      if (gapped) send_gapped(1'b1, 8'($urandom), now);
      else send_item(1'b1, 8'($urandom), now);
      send_reply(pos, now, gapped, -1);
   endtask

   // Extremes of fields, wrap both ways, zero interval, saturation, mismatches.
   task automatic test_directed();
      set_poll_config(8'h00, 16'h0000, 7'd1);
      poll_once(16'd100, 32'd7, 1'b0);           // zero interval keeps speed
      poll_once(16'd4000, 32'd1, 1'b0);          // wrap downward
      poll_once(16'd10, 32'd3, 1'b0);            // wrap upward
      poll_once(16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // max position and tick
      poll_once(16'h0000, 32'h0000_0000, 1'b0);
      poll_once(16'h7FFF, 32'h0000_0001, 1'b0);  // positive saturation
      poll_once(16'h0000, 32'h0000_0002, 1'b0);  // negative saturation
      send_item(1'b1, 8'h00, 32'd5);
      send_item(1'b1, 8'hFF, 32'd5);             // send while pending
      send_item(1'b0, 8'h55, 32'd6);             // wrong station byte
      drain();
      set_poll_config(8'hFF, 16'hFFFF, 7'd60);
      poll_once(16'd2048, 32'h1234_5678, 1'b0);
      drain();
      set_poll_config(8'h5A, 16'hA55A, 7'd0);    // count zero: five-byte reply
      poll_once(16'd3000, 32'h8000_0000, 1'b0);
      drain();
   endtask

   task automatic test_random_polls(input int n);
      logic [15:0] pos;
      int          r;
      logic [31:0] now;
      now = $urandom;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 9);
         now = now + $urandom_range(0, 3) * $urandom_range(0, 40000);
         pos = (r < 7) ? 16'($urandom_range(0, SPAN - 1)) : 16'($urandom);
         if (r == 8) begin
            send_gapped(1'b1, 8'($urandom), now);
            send_reply(pos, now, 1'b1, $urandom_range(0, 2));   // broken header
         end else if (r == 9) begin
            send_gapped(1'($urandom), 8'($urandom), now);        // noise
         end else begin
            poll_once(pos, now, 1'b1);
         end
      end
      drain();
   endtask

   // Receiver holds off while the sender keeps offering; the block backs up.
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int k = 0; k < 3; k++) poll_once(16'($urandom_range(0, SPAN - 1)), 32'(k * 50), 1'b0);
      go_quiet();
      hold_off = 1'b0;
      drain();
   endtask

   // Receiver stall process: random gaps, or a long counted hold-off.
   initial begin
      int n;
      int gap;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 300; n++) @(posedge clock);
            rsp_stall <= 1'b0;
            wait (!hold_off);
         end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   initial begin
      poll_beat_type e, a;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            a = {rsp_kind, rsp_tx_byte, rsp_last_byte, rsp_position, rsp_interval,
                 rsp_delta, rsp_speed, rsp_good_count, rsp_error_count};
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %h", a);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               if (a.kind !== e.kind) begin
                  $error("kind exp %0h got %0h", e.kind, a.kind); fail_count++;
               end
               if (a.tx_byte !== e.tx_byte) begin
                  $error("tx_byte exp %0h got %0h", e.tx_byte, a.tx_byte); fail_count++;
               end
               if (a.last_byte !== e.last_byte) begin
                  $error("last_byte exp %0h got %0h", e.last_byte, a.last_byte); fail_count++;
               end
               if (a.position !== e.position) begin
                  $error("position exp %0h got %0h", e.position, a.position); fail_count++;
               end
               if (a.interval !== e.interval) begin
                  $error("interval exp %0h got %0h", e.interval, a.interval); fail_count++;
               end
               if (a.delta !== e.delta) begin
                  $error("delta exp %0h got %0h", e.delta, a.delta); fail_count++;
               end
               if (a.speed !== e.speed) begin
                  $error("speed exp %0h got %0h", e.speed, a.speed); fail_count++;
               end
               if (a.good_count !== e.good_count) begin
                  $error("good_count exp %0h got %0h", e.good_count, a.good_count);
                  fail_count++;
               end
               if (a.error_count !== e.error_count) begin
                  $error("error_count exp %0h got %0h", e.error_count, a.error_count);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: stop when nothing moves on either channel for too long.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      cfg_station = mesp_pkg::STATION_RESET;
      cfg_start = mesp_pkg::START_RESET;
      cfg_count = mesp_pkg::COUNT_RESET;
      rx_seen = 0;
      for (int i = 0; i < 5; i++) hdr[i] = 8'h00;
      awaiting_reply = 1'b0;
      last_pos = 0;
      last_tick = 0;
      held_speed = 0;
      good_total = 0;
      error_total = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset values first: one poll before any register write.
      poll_once(16'd1, 32'd7, 1'b0);
      drain();
      test_directed();
      test_backpressure();
      set_poll_config(8'd2, 16'h0100, 7'd1);
      test_random_polls(3);
      set_poll_config(8'($urandom), 16'($urandom), 7'd2);
      test_random_polls(2);
      rsp_quiet = 1'b1;              // stretch with no receiver stalls
      set_poll_config(8'($urandom), 16'($urandom), 7'd1);
      test_random_polls(1);
      rsp_quiet = 1'b0;
      drain();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
